// ===== hdl/smt_pkg.sv =====
// Package for the sorted multiset table.
// Holds the transaction structs, operation codes, control types and capacity default.
// No dependencies.
package smt_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = 7;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	localparam logic [KEY_W-1:0] KEY_BIAS = {1'b1, {(KEY_W-1){1'b0}}};

	typedef struct packed {
		logic [1:0]              func;
		logic signed [KEY_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] occurrences;
		logic             present;
		logic [CNT_W-1:0] entries_now;
		logic             insert_dropped;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_INS,
		SH_DEL
	} shift_t;

	typedef struct packed {
		logic   cmp;
		shift_t shift;
	} cell_ctl_t;

endpackage

// ===== hdl/sorted_multiset_table.sv =====
// Sorted multiset table: a chain of cells holding signed keys in ascending order.
// The result strobe (done) follows the idle accept, compare and count-and-shift states;
// busy holds off a new item until the table is back in idle.
// Reset: table empty, idle; stored keys are not cleared. Receiver cannot stall.
// Depends on smt_pkg, smt_cell, smt_therm_enc.
module sorted_multiset_table #(
	parameter int CAPACITY = smt_pkg::CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  smt_pkg::cmd_t cmd,
	output logic          done,
	output smt_pkg::rsp_t result
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = smt_pkg::KEY_W;
	localparam int OW = smt_pkg::CNT_W;

	smt_pkg::state_t    state_q, state_d;
	smt_pkg::cell_ctl_t ctl;
	logic [1:0]         func_q;
	logic [KW-1:0]      key_q;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      lt_cnt, le_cnt, occ;
	logic               full, ins_ok, del_ok;
	smt_pkg::rsp_t      rsp_q, rsp_d;
	logic               done_q;

	logic [KW-1:0]       entry_a [CAPACITY];
	logic [CAPACITY-1:0] valid_a, lt_a, le_a;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KW-1:0] lkey, rkey;
		logic          lvalid, lle, rvalid;
		if (i == 0) begin : g_first
			assign lkey   = key_q;
			assign lvalid = 1'b1;
			assign lle    = 1'b1;
		end else begin : g_mid
			assign lkey   = entry_a[i-1];
			assign lvalid = valid_a[i-1];
			assign lle    = le_a[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign rkey   = key_q;
			assign rvalid = 1'b0;
		end else begin : g_inner
			assign rkey   = entry_a[i+1];
			assign rvalid = valid_a[i+1];
		end
		smt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (key_q),
			.left_key   (lkey),
			.left_valid (lvalid),
			.left_le    (lle),
			.right_key  (rkey),
			.right_valid(rvalid),
			.entry_q    (entry_a[i]),
			.valid_q    (valid_a[i]),
			.lt_q       (lt_a[i]),
			.le_q       (le_a[i])
		);
	end

	smt_therm_enc #(.N(CAPACITY), .W(CW)) u_lt_enc (.therm(lt_a), .count(lt_cnt));
	smt_therm_enc #(.N(CAPACITY), .W(CW)) u_le_enc (.therm(le_a), .count(le_cnt));

	assign occ    = le_cnt - lt_cnt;
	assign full   = (count_q == CW'(CAPACITY));
	assign ins_ok = (func_q == smt_pkg::FUNC_INSERT) && !full;
	assign del_ok = (func_q == smt_pkg::FUNC_REMOVE) && (occ != '0);

	always_comb begin
		logic [CW+OW-1:0] occ_ext, cnt_ext;
		state_d   = state_q;
		ctl.cmp   = 1'b0;
		ctl.shift = smt_pkg::SH_NONE;
		count_d   = count_q;
		if (ins_ok) begin
			count_d = count_q + CW'(1);
		end else if (del_ok) begin
			count_d = count_q - CW'(1);
		end
		occ_ext = {{OW{1'b0}}, occ};
		cnt_ext = {{OW{1'b0}}, count_d};
		rsp_d.occurrences    = occ_ext[OW-1:0];
		rsp_d.present        = (occ != '0);
		rsp_d.entries_now    = cnt_ext[OW-1:0];
		rsp_d.insert_dropped = (func_q == smt_pkg::FUNC_INSERT) && full;
		case (state_q)
			smt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = smt_pkg::ST_CMP;
				end
			end
			smt_pkg::ST_CMP: begin
				ctl.cmp = 1'b1;
				state_d = smt_pkg::ST_UPD;
			end
			smt_pkg::ST_UPD: begin
				if (ins_ok) begin
					ctl.shift = smt_pkg::SH_INS;
				end else if (del_ok) begin
					ctl.shift = smt_pkg::SH_DEL;
				end
				state_d = smt_pkg::ST_IDLE;
			end
			default: begin
				state_d = smt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smt_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == smt_pkg::ST_UPD);
			if (state_q == smt_pkg::ST_UPD) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == smt_pkg::ST_IDLE && start) begin
			func_q <= cmd.func;
			key_q  <= cmd.value ^ smt_pkg::KEY_BIAS;
		end
		if (state_q == smt_pkg::ST_UPD) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy   = (state_q != smt_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

endmodule

// ===== hdl/smt_cell.sv =====
// One cell of the sorted chain: holds one biased key and its valid bit.
// Registers its compare flags and shifts with its neighbors. Depends on smt_pkg.
module smt_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  smt_pkg::cell_ctl_t       ctl,
	input  logic [smt_pkg::KEY_W-1:0] key,
	input  logic [smt_pkg::KEY_W-1:0] left_key,
	input  logic                     left_valid,
	input  logic                     left_le,
	input  logic [smt_pkg::KEY_W-1:0] right_key,
	input  logic                     right_valid,
	output logic [smt_pkg::KEY_W-1:0] entry_q,
	output logic                     valid_q,
	output logic                     lt_q,
	output logic                     le_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			le_q    <= 1'b0;
		end else begin
			if (ctl.cmp) begin
				lt_q <= valid_q && (entry_q < key);
				le_q <= valid_q && (entry_q <= key);
			end
			case (ctl.shift)
				smt_pkg::SH_INS: begin
					if (!le_q) begin
						valid_q <= left_le ? 1'b1 : left_valid;
					end
				end
				smt_pkg::SH_DEL: begin
					if (!lt_q) begin
						valid_q <= right_valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.shift)
			smt_pkg::SH_INS: begin
				if (!le_q) begin
					entry_q <= left_le ? key : left_key;
				end
			end
			smt_pkg::SH_DEL: begin
				if (!lt_q) begin
					entry_q <= right_key;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/smt_therm_enc.sv =====
// Thermometer-to-binary encoder for the chain's compare flags.
// Counts the leading ones of a thermometer code. No dependencies.
module smt_therm_enc #(
	parameter int N = 64,
	parameter int W = 7
) (
	input  logic [N-1:0] therm,
	output logic [W-1:0] count
);

	always_comb begin
		count = '0;
		for (int j = 0; j < W; j++) begin
			for (int v = 1; v <= N; v++) begin
				if ((v & ((2 << j) - 1)) == (1 << j)) begin
					if (v + (1 << j) <= N) begin
						count[j] = count[j] | (therm[v-1] & ~therm[v+(1<<j)-1]);
					end else begin
						count[j] = count[j] | therm[v-1];
					end
				end
			end
		end
	end

endmodule

// ===== tb/sorted_multiset_table_tb.sv =====
// Testbench for sorted_multiset_table: directed and phased random insert/remove/query traffic,
// each done strobe checked field by field against an in-bench sorted multiset.
// Depends on smt_pkg and the sorted_multiset_table RTL.
module sorted_multiset_table_tb;
	import smt_pkg::*;

	localparam int ITEMS      = 1700;
	localparam int TAIL       = 150;
	localparam int MAX_CYCLES = 200000;
	localparam int SETTLE     = 8;
	localparam int POOL_MAX   = 12;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	cmd_t cmd    = '0;
	logic busy;
	logic done;
	rsp_t result;

	sorted_multiset_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	cmd_t pending_cmds [$];
	rsp_t awaited_rsp [$];
	logic signed [KEY_W-1:0] held_keys [CAPACITY];
	int held_count = 0;
	logic signed [KEY_W-1:0] live_keys [$];
	logic signed [KEY_W-1:0] key_pool [POOL_MAX];
	int pool_n = 1;

	bit took        = 1'b0;
	int gap_left    = 0;
	int cycle_cnt   = 0;
	int accepted_cnt = 0;
	int checked_cnt = 0;
	int mismatches  = 0;
	int n_insert    = 0;
	int n_remove    = 0;
	int n_query     = 0;
	int n_refused   = 0;
	int n_absent    = 0;
	int peak_occ    = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic rsp_t apply_to_multiset(cmd_t c);
		logic signed [KEY_W-1:0] v;
		int n;
		int hit;
		int pos;
		rsp_t r;
		v = $signed(c.value);
		n = 0;
		hit = -1;
		r = '0;
		for (int i = 0; i < held_count; i++) begin
			if (held_keys[i] == v) begin
				n++;
				if (hit < 0)
					hit = i;
			end
		end
		case (c.func)
			FUNC_INSERT: begin
				if (held_count >= CAPACITY) begin
					r.insert_dropped = 1'b1;
				end else begin
					pos = held_count;
					while (pos > 0 && held_keys[pos-1] > v) begin
						held_keys[pos] = held_keys[pos-1];
						pos--;
					end
					held_keys[pos] = v;
					held_count++;
				end
			end
			FUNC_REMOVE: begin
				if (hit >= 0) begin
					for (int j = hit; j + 1 < held_count; j++)
						held_keys[j] = held_keys[j+1];
					held_count--;
				end
			end
			default: ;
		endcase
		r.occurrences = n[CNT_W-1:0];
		r.present     = (n != 0);
		r.entries_now = held_count[CNT_W-1:0];
		return r;
	endfunction

	function automatic logic signed [KEY_W-1:0] pool_key();
		return key_pool[$urandom_range(0, pool_n - 1)];
	endfunction

	function automatic logic signed [KEY_W-1:0] fresh_pool_key();
		case ($urandom_range(0, 5))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_cmd(logic [1:0] f, logic signed [KEY_W-1:0] v);
		cmd_t c;
		c.func  = f;
		c.value = v;
		pending_cmds.push_back(c);
	endtask

	task automatic report_mismatch(string field, int got, int want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at cycle %0d, transaction %0d: %s got %0d expected %0d",
				cycle_cnt, checked_cnt, field, got, want);
	endtask

	// driver: present the next transaction once the current one is taken
	always @(negedge clk) begin
		logic nxt;
		if (arst_n && (!start || took)) begin
			nxt = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_cmds.size() > 0) begin
				if (pending_cmds.size() > TAIL && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 3);
				end else begin
					cmd <= pending_cmds.pop_front();
					nxt = 1'b1;
				end
			end
			start <= nxt;
		end
	end

	// monitor: check strobed results, then predict for the accepted transaction
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch("result with nothing awaited, done", 1, 0);
				end else begin
					want = awaited_rsp.pop_front();
					if (result.occurrences !== want.occurrences)
						report_mismatch("occurrences", result.occurrences, want.occurrences);
					if (result.present !== want.present)
						report_mismatch("present", result.present, want.present);
					if (result.entries_now !== want.entries_now)
						report_mismatch("entries_now", result.entries_now, want.entries_now);
					if (result.insert_dropped !== want.insert_dropped)
						report_mismatch("insert_dropped", result.insert_dropped,
							want.insert_dropped);
					checked_cnt++;
				end
			end
			took = start && !busy;
			if (took) begin
				want = apply_to_multiset(cmd);
				awaited_rsp.push_back(want);
				accepted_cnt++;
				if (want.occurrences > peak_occ)
					peak_occ = want.occurrences;
				case (cmd.func)
					FUNC_INSERT: begin
						n_insert++;
						if (want.insert_dropped)
							n_refused++;
					end
					FUNC_REMOVE: begin
						n_remove++;
						if (!want.present)
							n_absent++;
					end
					default: n_query++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d transactions accepted, %0d results awaited",
				cycle_cnt, accepted_cnt, awaited_rsp.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int phase;
		int n_phase;
		int ins_pct;
		int rem_pct;
		int r;
		int j;
		int total_items;
		logic signed [KEY_W-1:0] v;

		add_cmd(FUNC_QUERY, KEY_MIN);
		add_cmd(FUNC_REMOVE, KEY_MAX);
		add_cmd(FUNC_INSERT, '0);
		add_cmd(FUNC_INSERT, KEY_MIN);
		add_cmd(FUNC_INSERT, KEY_MAX);
		add_cmd(FUNC_INSERT, -1);
		add_cmd(FUNC_INSERT, '0);
		add_cmd(FUNC_INSERT, 1);
		add_cmd(FUNC_QUERY, '0);
		add_cmd(FUNC_UNUSED, '0);
		add_cmd(FUNC_QUERY, KEY_MAX);
		add_cmd(FUNC_REMOVE, '0);
		add_cmd(FUNC_REMOVE, '0);
		add_cmd(FUNC_REMOVE, '0);
		add_cmd(FUNC_REMOVE, KEY_MIN);
		add_cmd(FUNC_REMOVE, KEY_MAX);
		add_cmd(FUNC_REMOVE, -1);
		add_cmd(FUNC_REMOVE, 1);
		add_cmd(FUNC_QUERY, -1);

		// alternate fill and drain phases; a fresh key pool at each fill
		phase = 0;
		while (pending_cmds.size() < ITEMS) begin
			if (phase % 2 == 0) begin
				pool_n = (phase == 2) ? 1 : $urandom_range(2, POOL_MAX);
				for (int k = 0; k < pool_n; k++)
					key_pool[k] = fresh_pool_key();
				ins_pct = 72;
				rem_pct = 84;
			end else begin
				ins_pct = 12;
				rem_pct = 80;
			end
			n_phase = $urandom_range(220, 320);
			for (int k = 0; k < n_phase; k++) begin
				r = $urandom_range(0, 99);
				if (r < ins_pct) begin
					v = (pool_n > 1 && $urandom_range(0, 9) == 0) ? $urandom : pool_key();
					if (live_keys.size() < CAPACITY)
						live_keys.push_back(v);
					add_cmd(FUNC_INSERT, v);
				end else if (r < rem_pct) begin
					if (live_keys.size() > 0 && $urandom_range(0, 4) != 0) begin
						j = $urandom_range(0, live_keys.size() - 1);
						v = live_keys[j];
						live_keys.delete(j);
					end else begin
						v = $urandom_range(0, 1) ? $urandom : pool_key();
					end
					add_cmd(FUNC_REMOVE, v);
				end else begin
					if (live_keys.size() > 0 && $urandom_range(0, 4) != 0)
						v = live_keys[$urandom_range(0, live_keys.size() - 1)];
					else
						v = $urandom_range(0, 1) ? $urandom : pool_key();
					add_cmd((r < 98) ? FUNC_QUERY : FUNC_UNUSED, v);
				end
			end
			phase++;
		end
		total_items = pending_cmds.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (accepted_cnt == total_items);
		wait (awaited_rsp.size() == 0);
		repeat (SETTLE) @(posedge clk);

		$display("ran %0d transactions in %0d phases: %0d inserts (%0d refused when full),",
			accepted_cnt, phase, n_insert, n_refused);
		$display("%0d removes (%0d of absent keys), %0d queries; peak count of one key %0d",
			n_remove, n_absent, n_query, peak_occ);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
